/* rtl/srsl_pkg.sv */
// ----------------------------------------------------------------------------
// srsl_pkg
// Shared types and constants of the sorted range symbol lookup block.
// ----------------------------------------------------------------------------
package srsl_pkg;

	localparam int DEF_TABLE_DEPTH = 1024;

	localparam int ADDR_W     = 32;
	localparam int IDX_W      = 10;
	localparam int CNT_W      = 11;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FIXUP = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT = 1'b1;

	// request commands
	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	localparam logic [ADDR_W-1:0] RANGE_SLACK = 32'h0000_FFFF;

	// table read address select
	localparam logic [1:0] RD_LAST  = 2'd0;
	localparam logic [1:0] RD_FIRST = 2'd1;
	localparam logic [1:0] RD_NEXT  = 2'd2;

	typedef struct packed {
		logic              command;
		logic [IDX_W-1:0]  entry_index;
		logic [ADDR_W-1:0] entry_base;
		logic [ADDR_W-1:0] lookup_address;
	} in_item_t;

	typedef struct packed {
		logic              found;
		logic [IDX_W-1:0]  sym_slot;
		logic [ADDR_W-1:0] symbol_offset;
	} out_item_t;

	typedef struct packed {
		logic       wr_entry;
		logic       start;
		logic [1:0] rd_sel;
		logic       save_limit;
		logic       step;
		logic       set_hit;
		logic       set_miss;
		logic       load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic n_zero;
		logic n_one;
		logic range_ok;
		logic bracket;
		logic last;
		logic out_free;
	} ctrl_sts_t;

endpackage

/* rtl/srsl_if.sv */
// ----------------------------------------------------------------------------
// srsl_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface srsl_in_if;
	logic               valid;
	logic               ready;
	srsl_pkg::in_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface srsl_out_if;
	logic                valid;
	logic                ready;
	srsl_pkg::out_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

/* rtl/srsl_ram.sv */
// ----------------------------------------------------------------------------
// srsl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module srsl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/srsl_ctrl.sv */
// ----------------------------------------------------------------------------
// srsl_ctrl
// Sequencer of the table scan: range check, then one entry per cycle.
// ----------------------------------------------------------------------------
module srsl_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_command,
	output logic                  in_ready,
	input  srsl_pkg::ctrl_sts_t   sts,
	output srsl_pkg::ctrl_cmd_t   cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LAST  = 3'd1;
	localparam logic [2:0] ST_FIRST = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		cmd      = '0;
		cmd.rd_sel = srsl_pkg::RD_NEXT;
		in_ready = 1'b0;
		state_d  = state_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_command == srsl_pkg::CMD_WRITE) begin
						cmd.wr_entry = 1'b1;
					end else begin
						cmd.start  = 1'b1;
						cmd.rd_sel = srsl_pkg::RD_LAST;
						if (sts.n_zero) begin
							cmd.set_miss = 1'b1;
							state_d      = ST_DONE;
						end else begin
							state_d = ST_LAST;
						end
					end
				end
			end
			ST_LAST: begin
				// last base is on the read port, fetch the first one
				cmd.save_limit = 1'b1;
				cmd.rd_sel     = srsl_pkg::RD_FIRST;
				state_d        = ST_FIRST;
			end
			ST_FIRST: begin
				if (sts.n_one || !sts.range_ok) begin
					cmd.set_miss = 1'b1;
					state_d      = ST_DONE;
				end else begin
					cmd.step = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.bracket) begin
					cmd.set_hit = 1'b1;
					state_d     = ST_DONE;
				end else if (sts.last) begin
					cmd.set_miss = 1'b1;
					state_d      = ST_DONE;
				end else begin
					cmd.step = 1'b1;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* rtl/srsl_dp.sv */
// ----------------------------------------------------------------------------
// srsl_dp
// Datapath: configuration, base table, scan registers and result register.
// ----------------------------------------------------------------------------
module srsl_dp #(
	parameter int TABLE_DEPTH = srsl_pkg::DEF_TABLE_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [srsl_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [srsl_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  srsl_pkg::in_item_t                  in_item,
	output srsl_pkg::out_item_t                 out_item,
	output logic                                out_valid,
	input  logic                                out_ready,
	input  srsl_pkg::ctrl_cmd_t                 cmd,
	output srsl_pkg::ctrl_sts_t                 sts
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	logic [srsl_pkg::ADDR_W-1:0] fixup_q;
	logic [CW-1:0]               n_q;
	logic [srsl_pkg::ADDR_W-1:0] addr_q;
	logic [srsl_pkg::ADDR_W-1:0] limit_q;
	logic [srsl_pkg::ADDR_W-1:0] prev_q;
	logic [CW-1:0]               i_q;
	srsl_pkg::out_item_t         res_q;
	srsl_pkg::out_item_t         out_q;
	logic                        out_valid_q;

	logic [srsl_pkg::ADDR_W-1:0] rdata;
	logic [AW-1:0]               raddr;
	logic [AW-1:0]               waddr;
	logic                        we;
	logic [CW-1:0]               n_m1;
	logic [CW-1:0]               i_nxt;
	logic [CW-1:0]               i_m1;
	logic [31:0]                 cnt_wide;

	assign n_m1  = n_q - CW'(1);
	assign i_nxt = i_q + CW'(1);
	assign i_m1  = i_q - CW'(1);
	assign waddr = AW'(in_item.entry_index);
	assign we    = cmd.wr_entry && (32'(in_item.entry_index) < 32'(TABLE_DEPTH));
	assign cnt_wide = 32'(cfg_wdata[srsl_pkg::CNT_W-1:0]);

	always_comb begin
		unique case (cmd.rd_sel)
			srsl_pkg::RD_LAST:  raddr = n_m1[AW-1:0];
			srsl_pkg::RD_FIRST: raddr = '0;
			default:            raddr = i_nxt[AW-1:0];
		endcase
	end

	srsl_ram #(
		.WIDTH (srsl_pkg::ADDR_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (in_item.entry_base),
		.raddr (raddr),
		.rdata (rdata)
	);

	// configuration, count saturated to the table depth on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fixup_q <= '0;
			n_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				srsl_pkg::REG_FIXUP: fixup_q <= cfg_wdata;
				srsl_pkg::REG_COUNT: begin
					if (cnt_wide > 32'(TABLE_DEPTH)) begin
						n_q <= CW'(TABLE_DEPTH);
					end else begin
						n_q <= CW'(cnt_wide);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			addr_q <= in_item.lookup_address + fixup_q;
			i_q    <= '0;
		end
		if (cmd.save_limit) begin
			limit_q <= rdata + srsl_pkg::RANGE_SLACK;
		end
		if (cmd.step) begin
			prev_q <= rdata;
			i_q    <= i_nxt;
		end
		if (cmd.set_hit) begin
			res_q.found         <= 1'b1;
			res_q.sym_slot      <= srsl_pkg::IDX_W'(i_m1);
			res_q.symbol_offset <= addr_q - prev_q;
		end else if (cmd.set_miss) begin
			res_q <= '0;
		end
		if (cmd.load_out) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_item  = out_q;
	assign out_valid = out_valid_q;

	assign sts.n_zero   = (n_q == '0);
	assign sts.n_one    = (n_q == CW'(1));
	assign sts.range_ok = (addr_q >= rdata) && (addr_q < limit_q);
	assign sts.bracket  = (prev_q <= addr_q) && (addr_q < rdata);
	assign sts.last     = (i_nxt == n_q);
	assign sts.out_free = !out_valid_q || out_ready;

endmodule

/* rtl/sorted_range_symbol_lookup.sv */
// ----------------------------------------------------------------------------
// sorted_range_symbol_lookup
// Ascending base address table with bracketing lookup of fixed-up addresses.
// ----------------------------------------------------------------------------
// A write request stores one table entry. A lookup request with an empty
// table gives a miss without reading the table; one rejected by the range
// check, or with a single entry, gives a miss once the last and first bases
// are read; otherwise the result waits for the table scan: the table sits in
// one RAM with a single registered read port, so the scan reads one entry per
// cycle. The next request is taken from the cycle after the result is loaded;
// a stalled result delays that load. The result sits in an output register,
// so a new request is taken while an earlier result still waits.
module sorted_range_symbol_lookup #(
	parameter int TABLE_DEPTH = srsl_pkg::DEF_TABLE_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [srsl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [srsl_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	srsl_in_if.sink                          in_ch,
	srsl_out_if.source                       out_ch
);

	srsl_pkg::ctrl_cmd_t cmd;
	srsl_pkg::ctrl_sts_t sts;

	srsl_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_ch.valid),
		.in_command (in_ch.payload.command),
		.in_ready   (in_ch.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	srsl_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_item   (in_ch.payload),
		.out_item  (out_ch.payload),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

/* rtl/srsl_chk.sv */
// ----------------------------------------------------------------------------
// srsl_chk
// Port-level checks of the lookup block, bound to the top level.
// ----------------------------------------------------------------------------
module srsl_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          in_command,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          out_found,
	input logic [srsl_pkg::IDX_W-1:0]    out_index,
	input logic [srsl_pkg::ADDR_W-1:0]   out_offset
);

	// result held while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_found)
			&& $stable(out_index) && $stable(out_offset))
		else $error("result changed while stalled");

	// a miss reports zero index and offset
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_found |-> out_index == '0 && out_offset == '0)
		else $error("miss with nonzero index or offset");

	// a lookup occupies the block for at least the next cycle
	a_lookup_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_command == srsl_pkg::CMD_LOOKUP |=> !in_ready)
		else $error("request taken straight after a lookup");

	// a table write never produces a result
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_command == srsl_pkg::CMD_WRITE && !out_valid
			|=> !out_valid)
		else $error("result after a table write");

endmodule

bind sorted_range_symbol_lookup srsl_chk u_srsl_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.in_command (in_ch.payload.command),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.out_found  (out_ch.payload.found),
	.out_index  (out_ch.payload.sym_slot),
	.out_offset (out_ch.payload.symbol_offset)
);
